FILE: rtl/core/sli_pkg.sv
// Package for the sorted insertion list: field widths, operation and status
// codes, controller states and the controller-to-datapath command type.
// No dependencies; every other file of the block imports it.
package sli_pkg;

    localparam int VALUE_W          = 32;
    localparam int POS_W            = 5;
    localparam int MODE_W           = 2;
    localparam int STATUS_W         = 2;
    localparam int CNT_OUT_W        = 5;
    localparam int DEFAULT_CAPACITY = 16;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic exec;
    } t_dp_cmd;

endpackage

FILE: rtl/core/sli_ifs.sv
// Valid/ready channel interfaces for the sorted insertion list: one carries
// an operation item in, the other a result item out. Depends on sli_pkg.
interface sli_in_if
    import sli_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;

    modport source (output valid, mode, value, position, input ready);
    modport sink   (input valid, mode, value, position, output ready);
endinterface

interface sli_out_if
    import sli_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic [CNT_OUT_W-1:0]      entry_count;
    logic signed [VALUE_W-1:0] smallest;

    modport source (output valid, status, entry_count, smallest, input ready);
    modport sink   (input valid, status, entry_count, smallest, output ready);
endinterface

FILE: rtl/core/sorted_list_insert_delete_unit.sv
// Sorted insertion list: holds up to CAPACITY signed 32-bit values in
// ascending order. Depends on sli_pkg, sli_ifs, sli_ctrl and sli_dp.
//
// Use: each item on i_in carries a mode (insert, delete, clear), a value
// for insert and a 1-based position for delete. Every item yields exactly
// one result item on o_out: a status (done, full, out of range), the entry
// count after the operation and the smallest entry, zero when empty.
// Timing: an item is accepted when the block is idle; the whole operation,
// a parallel compare over all cells and one shift of the cell row, is
// done at that edge, so the result is valid on the next cycle. The block
// handles one item at a time: it accepts an item, presents its result and
// takes no new item until that result has been taken.
// When the receiver stalls, the result is held in its output register and
// i_in.ready stays low until the result is taken.
// Reset (synchronous, active low) empties the list and clears the
// handshake state; no clearing pass over the cells is needed, because only
// cells below the count are ever read.
module sorted_list_insert_delete_unit
    import sli_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    sli_in_if.sink   i_in,
    sli_out_if.source o_out
);

    t_dp_cmd cmd;
    logic    in_ready;
    logic    out_valid;

    sli_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    sli_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_mode        (i_in.mode),
        .i_value       (i_in.value),
        .i_position    (i_in.position),
        .o_status      (o_out.status),
        .o_entry_count (o_out.entry_count),
        .o_smallest    (o_out.smallest)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule

FILE: rtl/core/sli_ctrl.sv
// Controller of the sorted insertion list: a two-state machine that takes
// one item, fires the datapath and holds the result until taken. Uses sli_pkg.
module sli_ctrl
    import sli_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = (r_state == S_RESULT);
        o_cmd.exec  = (r_state == S_IDLE) && i_in_valid;
    end

endmodule

FILE: rtl/core/sli_dp.sv
// Datapath of the sorted insertion list: the row of value cells, the entry
// count, parallel compares, the shift network and the result registers.
// Uses sli_pkg.
module sli_dp
    import sli_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    input  logic [MODE_W-1:0]         i_mode,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic [POS_W-1:0]          i_position,
    output logic [STATUS_W-1:0]       o_status,
    output logic [CNT_OUT_W-1:0]      o_entry_count,
    output logic signed [VALUE_W-1:0] o_smallest
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic signed [VALUE_W-1:0] r_cell [CAPACITY];
    logic signed [VALUE_W-1:0] n_cell [CAPACITY];
    logic signed [VALUE_W-1:0] up_src [CAPACITY];
    logic signed [VALUE_W-1:0] dn_src [CAPACITY];
    logic [CW-1:0]             r_count, n_count;
    logic [STATUS_W-1:0]       r_status, n_status;
    logic [CNT_OUT_W-1:0]      r_count_out;
    logic signed [VALUE_W-1:0] r_smallest, n_smallest;
    logic [CAPACITY-1:0]       above;
    logic [CAPACITY-1:0]       prev_above;
    logic [CAPACITY-1:0]       shift_dn;
    logic [PW-1:0]             pos_ext, cnt_ext;
    logic                      full, del_ok;

    // A cell lies above the insert slot when it is unused or holds a larger
    // value; the list is sorted, so these cells form one run at the top.
    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            above[k]    = (CW'(k) >= r_count) || (r_cell[k] > i_value);
            shift_dn[k] = (PW'(k + 1) >= pos_ext);
        end
    end

    assign prev_above = {above[CAPACITY-2:0], 1'b0};

    always_comb begin
        up_src[0] = i_value;
        for (int k = 1; k < CAPACITY; k++) begin
            up_src[k] = r_cell[k-1];
        end
        for (int k = 0; k < CAPACITY - 1; k++) begin
            dn_src[k] = r_cell[k+1];
        end
        dn_src[CAPACITY-1] = r_cell[CAPACITY-1];
    end

    assign pos_ext = PW'(i_position);
    assign cnt_ext = PW'(r_count);
    assign full    = (r_count == CW'(CAPACITY));
    assign del_ok  = (i_position != '0) && (pos_ext <= cnt_ext);

    always_comb begin
        n_cell   = r_cell;
        n_count  = r_count;
        n_status = ST_DONE;
        unique case (i_mode)
            MODE_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    for (int k = 0; k < CAPACITY; k++) begin
                        if (above[k]) begin
                            n_cell[k] = prev_above[k] ? up_src[k] : i_value;
                        end
                    end
                    n_count = r_count + CW'(1);
                end
            end
            MODE_DELETE: begin
                if (!del_ok) begin
                    n_status = ST_RANGE;
                end else begin
                    for (int k = 0; k < CAPACITY; k++) begin
                        if (shift_dn[k]) begin
                            n_cell[k] = dn_src[k];
                        end
                    end
                    n_count = r_count - CW'(1);
                end
            end
            MODE_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
        n_smallest = (n_count != '0) ? n_cell[0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_cell      <= n_cell;
            r_status    <= n_status;
            r_count_out <= CNT_OUT_W'(n_count);
            r_smallest  <= n_smallest;
        end
    end

    assign o_status      = r_status;
    assign o_entry_count = r_count_out;
    assign o_smallest    = r_smallest;

endmodule

FILE: rtl/core/sli_checker.sv
// Port-level checks for the sorted insertion list, bound to the top level.
// Depends on sli_pkg and sorted_list_insert_delete_unit.
module sli_checker
    import sli_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [STATUS_W-1:0]  i_status,
    input logic [CNT_OUT_W-1:0] i_entry_count
);

    // Reset leaves no result pending.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // An accepted item shows its result on the next cycle.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("no result one cycle after an accepted item");

    // One item at a time: no new item while a result waits.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while a result is pending");

    // A stalled result holds its status and entry count.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_status) && $stable(i_entry_count))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == ST_DONE) || (i_status == ST_FULL) ||
            (i_status == ST_RANGE))
        else $error("undefined status code");

endmodule

bind sorted_list_insert_delete_unit sli_checker u_sli_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_status      (o_out.status),
    .i_entry_count (o_out.entry_count)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_list_insert_delete_unit: random and directed
// insert, delete and clear items, checked against a shadow copy of the sorted list.
// Depends on sli_pkg, sli_ifs and the RTL of the block.
module tb;
    import sli_pkg::*;

    localparam int LIST_DEPTH  = DEFAULT_CAPACITY;
    localparam int HALF_PERIOD = 4;
    localparam int RANDOM_OPS  = 525;
    localparam int WATCHDOG_NS = 2_000_000;
    localparam int SETTLE_CYCS = 10;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } t_list_op;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [CNT_OUT_W-1:0]      entry_count;
        logic signed [VALUE_W-1:0] smallest;
    } t_list_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sli_in_if  op_ch ();
    sli_out_if res_ch ();

    sorted_list_insert_delete_unit #(
        .CAPACITY(LIST_DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (op_ch),
        .o_out  (res_ch)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    t_list_op     list_ops_queue[$];
    t_list_result awaited_results[$];
    logic signed [VALUE_W-1:0] held_cells [LIST_DEPTH];
    int held_count   = 0;
    int ops_accepted = 0;
    int error_count  = 0;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // Both sides pause about a quarter of the time, except for a stretch of
    // items in the middle of the run where neither side pauses at all.
    function automatic bit take_a_break();
        if (ops_accepted >= 250 && ops_accepted < 350)
            return 1'b0;
        return $urandom_range(99) < 26;
    endfunction

    function automatic t_list_op make_op(input logic [MODE_W-1:0] mode,
                                         input logic signed [VALUE_W-1:0] value,
                                         input logic [POS_W-1:0] position);
        t_list_op op;
        op.mode     = mode;
        op.value    = value;
        op.position = position;
        return op;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3, 4: return VALUE_W'(int'($urandom_range(8)) - 4);
            default: return $urandom;
        endcase
    endfunction

    // Applies one item to the shadow list and returns the result it must give.
    function automatic t_list_result apply_to_shadow_list(input t_list_op op);
        t_list_result r;
        int slot;
        r.status = ST_DONE;
        case (op.mode)
            MODE_INSERT: begin
                if (held_count >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // Equal values stay ahead of the new one.
                    slot = 0;
                    while (slot < held_count && held_cells[slot] <= $signed(op.value))
                        slot++;
                    for (int k = held_count; k > slot; k--)
                        held_cells[k] = held_cells[k - 1];
                    held_cells[slot] = op.value;
                    held_count++;
                end
            end
            MODE_DELETE: begin
                if (op.position == 0 || op.position > held_count) begin
                    r.status = ST_RANGE;
                end else begin
                    for (int k = op.position - 1; k < held_count - 1; k++)
                        held_cells[k] = held_cells[k + 1];
                    held_count--;
                end
            end
            MODE_CLEAR: begin
                held_count = 0;
            end
            default: begin
            end
        endcase
        r.entry_count = CNT_OUT_W'(held_count);
        r.smallest    = (held_count > 0) ? held_cells[0] : '0;
        return r;
    endfunction

    // Driver: predicts each accepted item and presents the next one.
    always @(posedge i_clk) begin
        t_list_op op;
        if (!i_rst_n) begin
            op_ch.valid <= 1'b0;
        end else begin
            if (op_ch.valid && op_ch.ready) begin
                awaited_results.push_back(apply_to_shadow_list(
                    make_op(op_ch.mode, op_ch.value, op_ch.position)));
                ops_accepted++;
            end
            if (!op_ch.valid || op_ch.ready) begin
                if (list_ops_queue.size() != 0 && !take_a_break()) begin
                    op = list_ops_queue.pop_front();
                    op_ch.mode     <= op.mode;
                    op_ch.value    <= op.value;
                    op_ch.position <= op.position;
                    op_ch.valid    <= 1'b1;
                end else begin
                    op_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result against the oldest prediction.
    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result item arrived with none outstanding");
                end else begin
                    want = awaited_results.pop_front();
                    if (res_ch.status !== want.status)
                        report_mismatch($sformatf("status %0d, wanted %0d",
                                                  res_ch.status, want.status));
                    if (res_ch.entry_count !== want.entry_count)
                        report_mismatch($sformatf("entry_count %0d, wanted %0d",
                                                  res_ch.entry_count, want.entry_count));
                    if (res_ch.smallest !== want.smallest)
                        report_mismatch($sformatf("smallest %0d, wanted %0d",
                                                  res_ch.smallest, want.smallest));
                end
            end
            res_ch.ready <= !take_a_break();
        end
    end

    initial begin
        int total_ops;
        int planned_count;
        int roll;
        int pos;
        bit filling;

        i_rst_n         = 1'b0;
        op_ch.valid     = 1'b0;
        op_ch.mode      = MODE_INSERT;
        op_ch.value     = '0;
        op_ch.position  = '0;
        res_ch.ready    = 1'b0;

        // Operations on an empty list.
        list_ops_queue.push_back(make_op(MODE_DELETE, 32'sd0, 5'd1));
        list_ops_queue.push_back(make_op(MODE_DELETE, 32'sd0, 5'd0));
        list_ops_queue.push_back(make_op(MODE_CLEAR, 32'sd0, 5'd0));
        list_ops_queue.push_back(make_op(MODE_UNUSED, -32'sd1, 5'd31));
        // Seventeen inserts with extremes and duplicates; the list fills up.
        list_ops_queue.push_back(make_op(MODE_INSERT, 32'sh7FFF_FFFF, 5'd0));
        list_ops_queue.push_back(make_op(MODE_INSERT, 32'sh8000_0000, 5'd0));
        list_ops_queue.push_back(make_op(MODE_INSERT, 32'sd0, 5'd0));
        list_ops_queue.push_back(make_op(MODE_INSERT, 32'sd0, 5'd0));
        list_ops_queue.push_back(make_op(MODE_INSERT, -32'sd1, 5'd0));
        list_ops_queue.push_back(make_op(MODE_INSERT, 32'sd1, 5'd0));
        list_ops_queue.push_back(make_op(MODE_INSERT, 32'sh7FFF_FFFF, 5'd0));
        list_ops_queue.push_back(make_op(MODE_INSERT, 32'sh8000_0000, 5'd0));
        list_ops_queue.push_back(make_op(MODE_INSERT, 32'sd5, 5'd0));
        list_ops_queue.push_back(make_op(MODE_INSERT, -32'sd5, 5'd0));
        list_ops_queue.push_back(make_op(MODE_INSERT, 32'sh5555_5555, 5'd0));
        list_ops_queue.push_back(make_op(MODE_INSERT, 32'shAAAA_AAAA, 5'd0));
        list_ops_queue.push_back(make_op(MODE_INSERT, 32'sd7, 5'd0));
        list_ops_queue.push_back(make_op(MODE_INSERT, 32'sd7, 5'd0));
        list_ops_queue.push_back(make_op(MODE_INSERT, -32'sd100, 5'd0));
        list_ops_queue.push_back(make_op(MODE_INSERT, 32'sd12345, 5'd0));
        list_ops_queue.push_back(make_op(MODE_INSERT, 32'sd3, 5'd0));
        // Full list, bad positions, then the last and the first entry go.
        list_ops_queue.push_back(make_op(MODE_DELETE, 32'sd0, 5'd0));
        list_ops_queue.push_back(make_op(MODE_DELETE, 32'sd0, 5'd17));
        list_ops_queue.push_back(make_op(MODE_DELETE, 32'sd0, 5'd16));
        list_ops_queue.push_back(make_op(MODE_DELETE, 32'sd0, 5'd1));
        list_ops_queue.push_back(make_op(MODE_CLEAR, 32'sd0, 5'd0));

        // Random part: alternating phases that lean towards filling and
        // towards draining, so the list often runs full and empty.
        planned_count = 0;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            filling = ((n / 40) % 2) == 0;
            roll = $urandom_range(99);
            if (roll < 3) begin
                list_ops_queue.push_back(make_op(MODE_CLEAR, $urandom, POS_W'($urandom)));
                planned_count = 0;
            end else if (roll < 5) begin
                list_ops_queue.push_back(make_op(MODE_UNUSED, $urandom, POS_W'($urandom)));
            end else if (roll < (filling ? 75 : 35)) begin
                list_ops_queue.push_back(make_op(MODE_INSERT, pick_value(),
                                                 POS_W'($urandom)));
                if (planned_count < LIST_DEPTH)
                    planned_count++;
            end else begin
                if (planned_count > 0 && $urandom_range(9) < 8)
                    pos = $urandom_range(planned_count, 1);
                else
                    pos = $urandom_range(31);
                list_ops_queue.push_back(make_op(MODE_DELETE, $urandom, POS_W'(pos)));
                if (pos >= 1 && pos <= planned_count)
                    planned_count--;
            end
        end
        total_ops = list_ops_queue.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_accepted < total_ops || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCS) @(posedge i_clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #(WATCHDOG_NS);
        $display("TIMEOUT: outstanding results %0d", awaited_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
